// ----- hdl/dod_pkg.sv -----
// Shared types and code constants for the delta-of-delta timestamp encoder.
package dod_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned DATA_W = 72;  // code_bits + code_length, padded to bytes

  // Code lengths
  localparam logic [LEN_W-1:0] LEN_ZERO = 7'd1;
  localparam logic [LEN_W-1:0] LEN_7    = 7'd9;
  localparam logic [LEN_W-1:0] LEN_9    = 7'd12;
  localparam logic [LEN_W-1:0] LEN_12   = 7'd16;
  localparam logic [LEN_W-1:0] LEN_FRST = 7'd32;
  localparam logic [LEN_W-1:0] LEN_ESC  = 7'd36;
  localparam logic [LEN_W-1:0] LEN_HDR  = 7'd64;

  // Size prefixes, already placed above the value field
  localparam logic [TIME_W-1:0] PFX_7   = 64'h0000_0000_0000_0100;
  localparam logic [TIME_W-1:0] PFX_9   = 64'h0000_0000_0000_0C00;
  localparam logic [TIME_W-1:0] PFX_12  = 64'h0000_0000_0000_E000;
  localparam logic [TIME_W-1:0] PFX_ESC = 64'h0000_000F_0000_0000;

  // Delta stage to encode stage
  typedef struct packed {
    logic              valid;
    logic              first;
    logic [TIME_W-1:0] delta;
  } delta_t;

  // Encode stage to output register
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic              ovf;
    logic              last;
  } result_t;

endpackage

// ----- hdl/delta_of_delta_timestamp_encoder_top.sv -----
// Top level of the delta-of-delta timestamp encoder.
//
// Input channel (in_*): one 64-bit timestamp per beat on in_tdata.
// Output channel (out_*): one code word per beat; out_tdata carries the
// right-aligned code bits and their length, out_tuser flags an escape
// word whose 32-bit value lost high bits, out_tlast marks the final beat
// caused by an input timestamp.
// Configuration: cfg_wr_en with cfg_wr_data loads the block start time,
// used for the header and the first delta after reset.
// A timestamp is taken into the delta register, passes the encode logic
// and is then captured in the output register, from which its beat is
// offered on out_*. Throughput: one timestamp per cycle while out_tready
// is high; the first timestamp after reset produces two beats (header, then
// first delta) and so occupies the encode stage for both beats.
// Path: delta register, encode logic, output register; ready runs
// combinationally from out_tready back to in_tready, so a stalled receiver
// fills both registers and then drops in_tready, losing nothing.
// Reset (rst_n low, synchronous) empties all stages, clears the previous
// time and delta and re-arms the header for the next timestamp.
module delta_of_delta_timestamp_encoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dod_pkg::TIME_W-1:0] in_tdata,   // [63:0] sample_time
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dod_pkg::DATA_W-1:0] out_tdata,  // [63:0] code_bits, [70:64] code_length, [71] zero
  output logic                       out_tuser,  // [0] overflow
  output logic                       out_tlast,
  input  logic                       cfg_wr_en,
  input  logic [dod_pkg::TIME_W-1:0] cfg_wr_data
);

  logic [dod_pkg::TIME_W-1:0] block_start_r;
  dod_pkg::delta_t            dlt;
  logic                       dlt_ready;
  dod_pkg::result_t           res;
  logic                       res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_start_r <= '0;
    end else if (cfg_wr_en) begin
      block_start_r <= cfg_wr_data;
    end
  end

  dod_delta u_delta (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_time     (in_tdata),
    .block_start (block_start_r),
    .dlt         (dlt),
    .dlt_ready   (dlt_ready)
  );

  dod_encode u_encode (
    .clk         (clk),
    .rst_n       (rst_n),
    .dlt         (dlt),
    .dlt_ready   (dlt_ready),
    .block_start (block_start_r),
    .res         (res),
    .res_ready   (res_ready)
  );

  dod_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // only the header beat leaves an item unfinished
  a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[70:64] == dod_pkg::LEN_HDR)
    else $error("non-last beat is not a header");

  // overflow appears only on escape words
  a_ovf_escape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[70:64] == dod_pkg::LEN_ESC)
    else $error("overflow on a non-escape word");

  // a header beat taken is followed by the first delta
  a_hdr_then_first: assert property (@(posedge clk) disable iff (!rst_n)
    u_encode.take && u_encode.is_hdr |=> res.valid && res.len == dod_pkg::LEN_FRST)
    else $error("header not followed by first delta");

  // the single zero bit carries no set bits
  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[70:64] == dod_pkg::LEN_ZERO |-> out_tdata[63:0] == '0)
    else $error("one-bit code is not zero");
`endif

endmodule

// ----- hdl/dod_delta.sv -----
// Input register stage: registers a timestamp's delta from the last one or block start.
module dod_delta (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dod_pkg::TIME_W-1:0] in_time,
  input  logic [dod_pkg::TIME_W-1:0] block_start,
  output dod_pkg::delta_t            dlt,
  input  logic                       dlt_ready
);

  logic                       d_valid_r;
  logic                       d_first_r;
  logic [dod_pkg::TIME_W-1:0] d_delta_r;
  logic                       first_pending_r;
  logic [dod_pkg::TIME_W-1:0] prev_time_r;
  logic                       accept;
  logic [dod_pkg::TIME_W-1:0] base;

  assign in_ready = !d_valid_r || dlt_ready;
  assign accept   = in_valid && in_ready;
  // first item measures from the block start, later ones from the previous sample
  assign base     = first_pending_r ? block_start : prev_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r       <= 1'b0;
      first_pending_r <= 1'b1;
      prev_time_r     <= '0;
    end else begin
      if (accept) begin
        d_valid_r       <= 1'b1;
        first_pending_r <= 1'b0;
        prev_time_r     <= in_time;
      end else if (dlt_ready) begin
        d_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_first_r <= first_pending_r;
      d_delta_r <= in_time - base;
    end
  end

  assign dlt.valid = d_valid_r;
  assign dlt.first = d_first_r;
  assign dlt.delta = d_delta_r;

endmodule

// ----- hdl/dod_encode.sv -----
// Encode stage: delta-of-delta, zigzag, size class and the two-beat first item.
module dod_encode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dod_pkg::delta_t            dlt,
  output logic                       dlt_ready,
  input  logic [dod_pkg::TIME_W-1:0] block_start,
  output dod_pkg::result_t           res,
  input  logic                       res_ready
);

  logic                       hdr_done_r;
  logic [dod_pkg::TIME_W-1:0] prev_delta_r;
  logic [dod_pkg::TIME_W-1:0] dd;
  logic [dod_pkg::TIME_W-1:0] zz;
  logic                       take;
  logic                       is_hdr;

  assign dd     = dlt.delta - prev_delta_r;
  assign zz     = {dd[dod_pkg::TIME_W-2:0], 1'b0} ^ {dod_pkg::TIME_W{dd[dod_pkg::TIME_W-1]}};
  assign is_hdr = dlt.first && !hdr_done_r;
  assign take   = dlt.valid && res_ready;
  // hold the first item for a second beat after its header
  assign dlt_ready = res_ready && !is_hdr;

  always_comb begin
    res.valid = dlt.valid;
    res.bits  = '0;
    res.len   = dod_pkg::LEN_ZERO;
    res.ovf   = 1'b0;
    res.last  = 1'b1;
    if (is_hdr) begin
      res.bits = block_start;
      res.len  = dod_pkg::LEN_HDR;
      res.last = 1'b0;
    end else if (dlt.first) begin
      res.bits = {32'd0, dlt.delta[31:0]};
      res.len  = dod_pkg::LEN_FRST;
    end else if (dd == '0) begin
      res.bits = '0;
      res.len  = dod_pkg::LEN_ZERO;
    end else if (zz[63:7] == '0) begin
      res.bits = zz | dod_pkg::PFX_7;
      res.len  = dod_pkg::LEN_7;
    end else if (zz[63:9] == '0) begin
      res.bits = zz | dod_pkg::PFX_9;
      res.len  = dod_pkg::LEN_9;
    end else if (zz[63:12] == '0) begin
      res.bits = zz | dod_pkg::PFX_12;
      res.len  = dod_pkg::LEN_12;
    end else begin
      res.bits = dod_pkg::PFX_ESC | {32'd0, zz[31:0]};
      res.len  = dod_pkg::LEN_ESC;
      res.ovf  = (zz[63:32] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_done_r   <= 1'b0;
      prev_delta_r <= '0;
    end else if (take) begin
      if (is_hdr) begin
        hdr_done_r <= 1'b1;
      end else begin
        hdr_done_r   <= 1'b0;
        prev_delta_r <= dlt.delta;
      end
    end
  end

endmodule

// ----- hdl/dod_out.sv -----
// Output register: holds one result beat for the downstream receiver.
module dod_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dod_pkg::result_t           res,
  output logic                       res_ready,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dod_pkg::DATA_W-1:0] out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  logic                       o_valid_r;
  logic [dod_pkg::TIME_W-1:0] o_bits_r;
  logic [dod_pkg::LEN_W-1:0]  o_len_r;
  logic                       o_ovf_r;
  logic                       o_last_r;

  assign res_ready = !o_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (res_ready) begin
      o_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      o_bits_r <= res.bits;
      o_len_r  <= res.len;
      o_ovf_r  <= res.ovf;
      o_last_r <= res.last;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {1'b0, o_len_r, o_bits_r};
  assign out_tuser  = o_ovf_r;
  assign out_tlast  = o_last_r;

endmodule
